// ===== rtl/slipenc_pkg.sv =====
// Shared types and constants for the SLIP framing encoder transmit queue.
package slipenc_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [7:0] FRAME_END = 8'hC0;
    localparam logic [7:0] ESC       = 8'hDB;
    localparam logic [7:0] ESC_END   = 8'hDC;
    localparam logic [7:0] ESC_ESC   = 8'hDD;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       overflow;
        logic       queue_empty;
    } t_out_word;

    // One queue entry holds either a plain byte or the second byte of an
    // escape pair whose leading escape byte is implied.
    typedef struct packed {
        logic       pair;
        logic [7:0] value;
    } t_entry;

endpackage

// ===== rtl/slipenc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slipenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/slip_frame_encoder_tx_queue_top.sv =====
// Top level of the SLIP framing encoder with its circular transmit queue.
// A result word is presented in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless the output stalls; the queue head
// is prefetched from the RAM so that a pop never waits on the registered read.
// Reset: pointers, byte count, escape phase and output valid are cleared;
// the queue RAM contents are undefined until written.
module slip_frame_encoder_tx_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  slipenc_pkg::t_in_word i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output slipenc_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH);
    localparam int EW = $bits(slipenc_pkg::t_entry);

    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_half, n_half;
    logic          r_out_valid;
    slipenc_pkg::t_out_word r_out_word, n_out_word;

    logic                 r_byp_hit;
    slipenc_pkg::t_entry  r_byp_data;
    slipenc_pkg::t_entry  head;
    logic [EW-1:0]        ram_q;

    logic                 accept;
    logic                 wr_en;
    slipenc_pkg::t_entry  wr_entry;
    logic [CW:0]          need;
    logic                 fits;
    logic                 is_pair;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;

    assign head = r_byp_hit ? r_byp_data : slipenc_pkg::t_entry'(ram_q);

    assign is_pair = (i_in_word.data_byte == slipenc_pkg::FRAME_END) ||
                     (i_in_word.data_byte == slipenc_pkg::ESC);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count = r_count;
        n_half = r_half;
        wr_en = 1'b0;
        wr_entry.pair = 1'b0;
        wr_entry.value = slipenc_pkg::FRAME_END;
        need = (CW+1)'(1);
        n_out_word.tx_valid = 1'b0;
        n_out_word.tx_byte = 8'h00;
        n_out_word.overflow = 1'b0;

        case (i_in_word.opcode)
            slipenc_pkg::OP_DATA: begin
                if (is_pair) begin
                    need = (CW+1)'(2);
                    wr_entry.pair = 1'b1;
                    wr_entry.value = (i_in_word.data_byte == slipenc_pkg::FRAME_END) ?
                                     slipenc_pkg::ESC_END : slipenc_pkg::ESC_ESC;
                end else begin
                    wr_entry.value = i_in_word.data_byte;
                end
            end
            default: begin
            end
        endcase

        fits = ({1'b0, r_count} + need) <= (CW+1)'(DEPTH - 1);

        case (i_in_word.opcode)
            slipenc_pkg::OP_BEGIN, slipenc_pkg::OP_DATA: begin
                if (fits) begin
                    wr_en = accept;
                    n_count = r_count + CW'(need);
                    n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                end else begin
                    n_out_word.overflow = 1'b1;
                end
            end
            slipenc_pkg::OP_POP: begin
                if (r_count != '0) begin
                    n_out_word.tx_valid = 1'b1;
                    n_count = r_count - 1'b1;
                    if (head.pair && !r_half) begin
                        n_out_word.tx_byte = slipenc_pkg::ESC;
                        n_half = 1'b1;
                    end else begin
                        n_out_word.tx_byte = head.value;
                        n_half = 1'b0;
                        n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (!accept) begin
            n_rd_ptr = r_rd_ptr;
            n_wr_ptr = r_wr_ptr;
            n_count = r_count;
            n_half = r_half;
        end

        n_out_word.queue_empty = (n_count == '0);
    end

    slipenc_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_wr_ptr),
        .i_wr_data(wr_entry),
        .i_rd_addr(n_rd_ptr),
        .o_rd_data(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count <= '0;
            r_half <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count <= n_count;
            r_half <= n_half;
            r_byp_hit <= wr_en && (r_wr_ptr == n_rd_ptr);
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_entry;
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
